### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/lcas_pkg.sv
// ----------------------------------------------------------------------------
// lcas_pkg
// Shared constants and control types of the life grid stepper.
// ----------------------------------------------------------------------------
package lcas_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 32;

    typedef logic [1:0] t_op;

    localparam t_op OP_CLEAR = 2'd0;
    localparam t_op OP_SET   = 2'd1;
    localparam t_op OP_STEP  = 2'd2;
    localparam t_op OP_READ  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic clr;        // kill every cell
        logic item_rd;    // read row of captured coordinate
        logic set_wr;     // write back row with cell set
        logic sample;     // take cell bit for a read
        logic step_init;  // start generation sweep
        logic step_rd;    // read next row of sweep
        logic step_sh;    // shift window, write finished row
        logic done;       // load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic in_range;
        logic step_last;
        logic out_free;
    } t_stat;

endpackage

### hw/rtl/lcas_ctrl.sv
// ----------------------------------------------------------------------------
// lcas_ctrl
// Sequencer: decodes each beat and drives the datapath through its steps.
// ----------------------------------------------------------------------------
module lcas_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lcas_pkg::t_stat i_stat,
    output lcas_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DEC     = 3'd1;
    localparam logic [2:0] ST_SET_WR  = 3'd2;
    localparam logic [2:0] ST_RD_WAIT = 3'd3;
    localparam logic [2:0] ST_S_RD    = 3'd4;
    localparam logic [2:0] ST_S_SH    = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DEC;
                end
            end
            ST_DEC: begin
                case (i_stat.op)
                    lcas_pkg::OP_CLEAR: begin
                        o_cmd.clr = 1'b1;
                        n_state   = ST_DONE;
                    end
                    lcas_pkg::OP_SET: begin
                        o_cmd.item_rd = i_stat.in_range;
                        n_state       = i_stat.in_range ? ST_SET_WR : ST_DONE;
                    end
                    lcas_pkg::OP_STEP: begin
                        o_cmd.step_init = 1'b1;
                        n_state         = ST_S_RD;
                    end
                    default: begin
                        o_cmd.item_rd = i_stat.in_range;
                        n_state       = i_stat.in_range ? ST_RD_WAIT : ST_DONE;
                    end
                endcase
            end
            ST_SET_WR: begin
                o_cmd.set_wr = 1'b1;
                n_state      = ST_DONE;
            end
            ST_RD_WAIT: begin
                o_cmd.sample = 1'b1;
                n_state      = ST_DONE;
            end
            ST_S_RD: begin
                o_cmd.step_rd = 1'b1;
                n_state       = ST_S_SH;
            end
            ST_S_SH: begin
                o_cmd.step_sh = 1'b1;
                n_state       = i_stat.step_last ? ST_DONE : ST_S_RD;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/lcas_dp.sv
// ----------------------------------------------------------------------------
// lcas_dp
// Datapath: row-wide grid memory, row valid bits, three-row window with
// the B3/S23 rule across a whole row, and the result register.
// ----------------------------------------------------------------------------
module lcas_dp #(
    parameter int GRID_WIDTH  = lcas_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lcas_pkg::GRID_HEIGHT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lcas_pkg::t_cmd  i_cmd,
    output lcas_pkg::t_stat o_stat,
    input  lcas_pkg::t_op   i_op,
    input  logic [7:0]      i_col,
    input  logic [7:0]      i_row,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_out_in_range,
    output logic            o_out_alive
);

    localparam int XW  = $clog2(GRID_WIDTH);
    localparam int RW  = $clog2(GRID_HEIGHT);
    localparam int RCW = $clog2(GRID_HEIGHT + 1);

    // grid memory, one row per word
    logic [GRID_WIDTH-1:0]  mem [GRID_HEIGHT];
    logic [GRID_HEIGHT-1:0] r_vld;

    logic [GRID_WIDTH-1:0] r_rd_data;
    logic                  r_rd_ok;
    logic [GRID_WIDTH-1:0] rd_row_data;

    logic                  rd_en;
    logic [RW-1:0]         rd_addr;
    logic                  wr_en;
    logic [RW-1:0]         wr_addr;
    logic [GRID_WIDTH-1:0] wr_data;

    // captured beat
    lcas_pkg::t_op r_op;
    logic [7:0]    r_col;
    logic [7:0]    r_row;
    logic          r_inr;
    logic          r_alive;
    logic          in_grid;

    // sweep state
    logic [RCW-1:0]        r_rd_row;
    logic [RCW-1:0]        wr_step_row;
    logic                  step_last;
    logic [GRID_WIDTH-1:0] r_win_up;
    logic [GRID_WIDTH-1:0] r_win_mid;
    logic [GRID_WIDTH+1:0] p_up;
    logic [GRID_WIDTH+1:0] p_mid;
    logic [GRID_WIDTH+1:0] p_dn;
    logic [GRID_WIDTH-1:0] nxt_row;

    // result register
    logic r_out_vld;
    logic r_out_inr;
    logic r_out_alive;
    logic out_free;

    assign in_grid = ({1'b0, i_col} < 9'(GRID_WIDTH)) && ({1'b0, i_row} < 9'(GRID_HEIGHT));

    // a row never written since reset or clear reads as all dead
    assign rd_row_data = r_rd_ok ? r_rd_data : '0;

    assign step_last   = (r_rd_row == RCW'(GRID_HEIGHT));
    assign wr_step_row = r_rd_row - RCW'(1);

    assign rd_en   = i_cmd.item_rd || (i_cmd.step_rd && !step_last);
    assign rd_addr = i_cmd.item_rd ? r_row[RW-1:0] : r_rd_row[RW-1:0];

    assign wr_en   = i_cmd.set_wr || (i_cmd.step_sh && (r_rd_row != '0));
    assign wr_addr = i_cmd.set_wr ? r_row[RW-1:0] : wr_step_row[RW-1:0];
    assign wr_data = i_cmd.set_wr ? (rd_row_data | (GRID_WIDTH'(1) << r_col[XW-1:0]))
                                  : nxt_row;

    // window during shift: up = r_win_up, mid = r_win_mid, down = incoming row
    assign p_up  = {1'b0, r_win_up, 1'b0};
    assign p_mid = {1'b0, r_win_mid, 1'b0};
    assign p_dn  = {1'b0, rd_row_data, 1'b0};

    always_comb begin
        logic [3:0] cnt;
        cnt = '0;
        for (int x = 0; x < GRID_WIDTH; x++) begin
            cnt = 4'(p_up[x]) + 4'(p_up[x+1]) + 4'(p_up[x+2])
                + 4'(p_mid[x]) + 4'(p_mid[x+2])
                + 4'(p_dn[x]) + 4'(p_dn[x+1]) + 4'(p_dn[x+2]);
            nxt_row[x] = (cnt == 4'd3) || (p_mid[x+1] && (cnt == 4'd2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= rd_en && r_vld[rd_addr];
            if (i_cmd.clr) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_col   <= i_col;
            r_row   <= i_row;
            r_inr   <= (i_op == lcas_pkg::OP_CLEAR) || (i_op == lcas_pkg::OP_STEP) || in_grid;
            r_alive <= 1'b0;
        end else if (i_cmd.sample) begin
            r_alive <= rd_row_data[r_col[XW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_row <= '0;
        end else if (i_cmd.step_init) begin
            r_rd_row <= '0;
        end else if (i_cmd.step_sh && !step_last) begin
            r_rd_row <= r_rd_row + RCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_init) begin
            r_win_up  <= '0;
            r_win_mid <= '0;
        end else if (i_cmd.step_sh) begin
            r_win_up  <= r_win_mid;
            r_win_mid <= rd_row_data;
        end
    end

    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.done) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            r_out_inr   <= r_inr;
            r_out_alive <= r_alive;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.in_range  = r_inr;
    assign o_stat.step_last = step_last;
    assign o_stat.out_free  = out_free;

    assign o_out_valid    = r_out_vld;
    assign o_out_in_range = r_out_inr;
    assign o_out_alive    = r_out_alive;

endmodule

### hw/rtl/life_cellular_automaton_step_top.sv
// ----------------------------------------------------------------------------
// life_cellular_automaton_step_top
// Bounded B3/S23 life grid with clear, set, step and read commands.
//
//   channel   dir  fields
//   s_axis    in   tuser: op ; tdata: col, row
//   m_axis    out  tdata: in_range, alive
//
// Clear, set and read each pass through decode and done; step sweeps the grid:
// it reads one grid row from the row memory, then writes the finished row
// above it, computing all cells of a row at once.
// Reset clears the per-row valid bits at once; no clearing pass is needed.
// A finished result sits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module life_cellular_automaton_step_top #(
    parameter int GRID_WIDTH  = lcas_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lcas_pkg::GRID_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] col, [15:8] row
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [0] in_range, [1] alive, [7:2] zero
);

    lcas_pkg::t_cmd  cmd;
    lcas_pkg::t_stat stat;
    logic            out_inr;
    logic            out_alive;

    lcas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lcas_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_s_axis_tuser),
        .i_col          (i_s_axis_tdata[7:0]),
        .i_row          (i_s_axis_tdata[15:8]),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_out_in_range (out_inr),
        .o_out_alive    (out_alive)
    );

    assign o_m_axis_tdata = {6'b0, out_alive, out_inr};

endmodule

### hw/rtl/lcas_chk.sv
// ----------------------------------------------------------------------------
// lcas_chk
// Port-level checker for the life grid stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcas_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [15:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata
);

    logic in_beat;
    logic out_stall;

    assign in_beat   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // one beat in flight: the block is busy right after taking one
    `ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, in_beat, !o_s_axis_tready)

    // a live cell is only reported for an in-range read
    `ASSERT_IMPLIES(a_alive_in_range, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[1], o_m_axis_tdata[0])

    // a new result appears only as the block finishes a beat
    `ASSERT_IMPLIES(a_result_at_finish, i_clk, i_rst_n, $rose(o_m_axis_tvalid), !$past(o_s_axis_tready))

    // idle bits stay zero
    `ASSERT_IMPLIES(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[7:2] == 6'b0)

endmodule

bind life_cellular_automaton_step_top lcas_chk u_lcas_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
